[hdl/cross_stencil_blur_stream_defines.svh]
// Assertion macros for the five-point blur stream.
`ifndef CROSS_STENCIL_BLUR_STREAM_DEFINES_SVH
`define CROSS_STENCIL_BLUR_STREAM_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CSB_ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csb: property violated");

`define CSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csb: next-cycle property violated");

`else

`define CSB_ASSERT_HOLDS(label, clk, rst_n, prop)

`define CSB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/csb_pkg.sv]
`default_nettype none

package csb_pkg;

  localparam int CH_W      = 16;
  localparam int NUM_CH    = 3;
  localparam int PX_W      = CH_W * NUM_CH;
  localparam int POS_W     = 9;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W     = CH_W + 3;

  localparam int FW_RESET  = 480;
  localparam int FH_RESET  = 360;
  localparam int SIZE_MIN  = 3;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PX_W-1:0] px_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    px_t              first_px;
    px_t              cur_px;
    logic             has_first;
    logic             bottom;
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic int clamp_size(int v, int hi);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/csb_pix_if.sv]
`default_nettype none

interface csb_pix_if import csb_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic            frame_start;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_start, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input frame_start, output ready);
endinterface

`default_nettype wire

[hdl/csb_res_if.sv]
`default_nettype none

interface csb_res_if import csb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_column;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic             run_last;

  modport source (output valid, output out_row, output out_column, output red_out,
                  output green_out, output blue_out, output run_last, input ready);
  modport sink   (input valid, input out_row, input out_column, input red_out,
                  input green_out, input blue_out, input run_last, output ready);
endinterface

`default_nettype wire

[hdl/csb_cfg_if.sv]
`default_nettype none

interface csb_cfg_if import csb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/csb_ram.sv]
`default_nettype none

module csb_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a_r,
  output logic      [WIDTH-1:0]         rdata_b_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

[hdl/csb_front.sv]
`default_nettype none

module csb_front import csb_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  csb_pix_if.sink       pix,
  csb_cfg_if.sink       cfg,
  input  wire q_stat_t  q_stat,
  output logic          q_push,
  output q_entry_t      q_entry
);

  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int YW        = $clog2(MAX_HEIGHT);
  localparam int RAM_DEPTH = 2 ** XW;
  localparam int ENT_W     = 2 * PX_W;

  logic [WW-1:0]    fw_r, fw_nxt;
  logic [HW-1:0]    fh_r, fh_nxt;
  logic [XW-1:0]    col_r, col_nxt;
  logic [YW-1:0]    row_r, row_nxt;

  logic             accept;
  logic             ready;
  logic [XW-1:0]    c0;
  logic [YW:0]      r0;
  logic [YW:0]      r1;
  logic [XW-1:0]    x;
  logic [YW-1:0]    y;
  logic [XW-1:0]    x_plus;
  logic [YW:0]      y_plus;
  px_t              cur_in;

  logic             s1_vld_r;
  logic [XW-1:0]    s1_x_r;
  logic [YW-1:0]    s1_y_r;
  px_t              s1_cur_r;
  logic             s1_first_r;
  logic             s1_interior_r;
  logic             s1_bottom_r;
  logic             fwd_a_r;
  logic             fwd_b_r;
  logic [ENT_W-1:0] wr_q_r;
  px_t              prev_center_r;

  logic [ENT_W-1:0] rd_a;
  logic [ENT_W-1:0] rd_b;
  logic [ENT_W-1:0] ent_a;
  logic [ENT_W-1:0] ent_b;
  logic [ENT_W-1:0] wdata;
  px_t              center_px;
  px_t              north_px;
  px_t              east_px;
  px_t              res_px;
  logic [SUM_W-1:0] ch_sum [NUM_CH];

  // configuration, clamped at write time
  assign cfg.ready = 1'b1;

  always_comb begin
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    if (cfg.valid) begin
      case (cfg.index)
        REG_FRAME_WIDTH:  fw_nxt = WW'(clamp_size(int'(cfg.data), MAX_WIDTH));
        REG_FRAME_HEIGHT: fh_nxt = HW'(clamp_size(int'(cfg.data), MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // position of the arriving pixel and of the next one
  assign ready    = (q_stat.count + QCNT_W'(s1_vld_r)) < QCNT_W'(QDEPTH);
  assign pix.ready = ready;
  assign accept   = pix.valid && ready;
  assign cur_in   = {pix.blue_in, pix.green_in, pix.red_in};

  always_comb begin
    c0 = pix.frame_start ? '0 : col_r;
    r0 = pix.frame_start ? '0 : {1'b0, row_r};
    r1 = r0;
    if (32'(c0) >= 32'(fw_r)) begin
      c0 = '0;
      r1 = r0 + (YW+1)'(1);
    end
    if (32'(r1) >= 32'(fh_r)) begin
      r1 = '0;
    end
    x      = c0;
    y      = r1[YW-1:0];
    x_plus = x + XW'(1);
    y_plus = {1'b0, y} + (YW+1)'(1);

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (32'(x) + 32'd1 >= 32'(fw_r)) begin
        col_nxt = '0;
        row_nxt = (32'(y_plus) >= 32'(fh_r)) ? '0 : y_plus[YW-1:0];
      end else begin
        col_nxt = x_plus;
        row_nxt = y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= WW'(clamp_size(FW_RESET, MAX_WIDTH));
      fh_r     <= HW'(clamp_size(FH_RESET, MAX_HEIGHT));
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      fw_r     <= fw_nxt;
      fh_r     <= fh_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r        <= x;
      s1_y_r        <= y;
      s1_cur_r      <= cur_in;
      s1_first_r    <= (y != '0);
      s1_interior_r <= (32'(y) >= 32'd2) && (x != '0) && (32'(x) != 32'(fw_r) - 32'd1);
      s1_bottom_r   <= (32'(y) == 32'(fh_r) - 32'd1);
      fwd_a_r       <= s1_vld_r && (s1_x_r == x);
      fwd_b_r       <= s1_vld_r && (s1_x_r == x_plus);
    end
    if (s1_vld_r) begin
      wr_q_r        <= wdata;
      prev_center_r <= center_px;
    end
  end

  // line store: entry x holds {row y-2, row y-1} at column x
  csb_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RAM_DEPTH)
  ) u_line_ram (
    .clk       (clk),
    .we        (s1_vld_r),
    .waddr     (s1_x_r),
    .wdata     (wdata),
    .raddr_a   (x),
    .raddr_b   (x_plus),
    .rdata_a_r (rd_a),
    .rdata_b_r (rd_b)
  );

  // stencil stage
  always_comb begin
    ent_a     = fwd_a_r ? wr_q_r : rd_a;
    ent_b     = fwd_b_r ? wr_q_r : rd_b;
    center_px = ent_a[PX_W-1:0];
    north_px  = ent_a[ENT_W-1:PX_W];
    east_px   = ent_b[PX_W-1:0];
    wdata     = {center_px, s1_cur_r};
    res_px    = center_px;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_sum[c] = {1'b0, center_px[c*CH_W +: CH_W], 2'b00}
                + SUM_W'(north_px[c*CH_W +: CH_W])
                + SUM_W'(s1_cur_r[c*CH_W +: CH_W])
                + SUM_W'(east_px[c*CH_W +: CH_W])
                + SUM_W'(prev_center_r[c*CH_W +: CH_W]);
      if (s1_interior_r) begin
        res_px[c*CH_W +: CH_W] = ch_sum[c][SUM_W-1:3];
      end
    end
  end

  assign q_push            = s1_vld_r && (s1_first_r || s1_bottom_r);
  assign q_entry.row       = POS_W'(s1_y_r);
  assign q_entry.col       = POS_W'(s1_x_r);
  assign q_entry.first_px  = res_px;
  assign q_entry.cur_px    = s1_cur_r;
  assign q_entry.has_first = s1_first_r;
  assign q_entry.bottom    = s1_bottom_r;

endmodule

`default_nettype wire

[hdl/csb_queue.sv]
`default_nettype none

module csb_queue import csb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_stat_t       stat
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));

endmodule

`default_nettype wire

[hdl/csb_back.sv]
`default_nettype none

module csb_back import csb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_entry_t head,
  input  wire q_stat_t  q_stat,
  output logic          pop,
  csb_res_if.source     res
);

  logic             out_vld_r, out_vld_nxt;
  logic             phase_r, phase_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0] col_r, col_nxt;
  px_t              px_r, px_nxt;
  logic             last_r, last_nxt;

  logic             slot_free;
  logic             load;
  logic             second;

  always_comb begin
    slot_free   = !out_vld_r || res.ready;
    load        = slot_free && !q_stat.empty;
    second      = phase_r || !head.has_first;
    pop         = load && (second || !head.bottom);
    out_vld_nxt = slot_free ? !q_stat.empty : out_vld_r;
    phase_nxt   = load ? (!second && head.bottom) : phase_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    px_nxt      = px_r;
    last_nxt    = last_r;
    if (load) begin
      col_nxt = head.col;
      if (second) begin
        row_nxt  = head.row;
        px_nxt   = head.cur_px;
        last_nxt = 1'b1;
      end else begin
        row_nxt  = head.row - POS_W'(1);
        px_nxt   = head.first_px;
        last_nxt = !head.bottom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      phase_r   <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    px_r   <= px_nxt;
    last_r <= last_nxt;
  end

  assign res.valid      = out_vld_r;
  assign res.out_row    = row_r;
  assign res.out_column = col_r;
  assign res.red_out    = px_r[0*CH_W +: CH_W];
  assign res.green_out  = px_r[1*CH_W +: CH_W];
  assign res.blue_out   = px_r[2*CH_W +: CH_W];
  assign res.run_last   = last_r;

endmodule

`default_nettype wire

[hdl/cross_stencil_blur_stream.sv]
// Five-point blur over a raster stream of U8.8 RGB pixels.
// in_pix: one pixel per transaction, frame_start marks pixel (0,0); without
//   it the position advances and wraps at frame end on its own.
// cfg_bus: index 0 sets frame_width, index 1 frame_height, clamped to
//   3..MAX_WIDTH / 3..MAX_HEIGHT; write only while the stream is idle.
// out_res: pixel (y,x) arriving releases the result for (y-1,x); a bottom-row
//   pixel also releases itself, so it gives two transactions, run_last on the
//   second. Top-row pixels give nothing. Border pixels pass unchanged.
// Throughput: one pixel per cycle while the queue has room; on the bottom row
//   each pixel gives two results through the single output register, so the
//   rate drops there.
// Reset: position (0,0), size 480 x 360 (clamped). Line stores are not
//   cleared; the first two rows of the first frame fill them.
// A 4-entry queue sits between stencil and output; when out_res stalls it
//   fills and in_pix.ready drops, with nothing lost.
`default_nettype none
`include "cross_stencil_blur_stream_defines.svh"

module cross_stencil_blur_stream import csb_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic clk,
  input  wire logic rst_n,
  csb_pix_if.sink   in_pix,
  csb_res_if.source out_res,
  csb_cfg_if.sink   cfg_bus
);

  logic     q_push;
  logic     q_pop;
  q_entry_t q_entry;
  q_entry_t q_head;
  q_stat_t  q_stat;

  csb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (in_pix),
    .cfg     (cfg_bus),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  csb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  csb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .q_stat (q_stat),
    .pop    (q_pop),
    .res    (out_res)
  );

  `CSB_ASSERT_HOLDS(a_queue_no_overflow, clk, rst_n, q_push |-> !q_stat.full)
  `CSB_ASSERT_HOLDS(a_queue_no_underflow, clk, rst_n, q_pop |-> !q_stat.empty)
  `CSB_ASSERT_NEXT(a_second_follows, clk, rst_n, out_res.valid && out_res.ready && !out_res.run_last, out_res.valid)

endmodule

`default_nettype wire

[dv/tb_cross_stencil_blur_stream.sv]
`timescale 1ns / 100ps

module tb_cross_stencil_blur_stream;
  import csb_pkg::*;

  localparam int FRAME_MAX    = 512;
  localparam int CFG_MAX      = (1 << CFG_W) - 1;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 280;
  localparam int QUIET_ITEMS  = 210;
  localparam logic [CH_W-1:0] STRIPES [4] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             run_last;
  } blur_result_t;

  class blur_checker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    px_t              two_up [FRAME_MAX];
    px_t              one_up [FRAME_MAX];
    int               next_row;
    int               next_col;
    blur_result_t     pending_pixels [$];
    int               errors;
    int               checked;
    int               noted;

    function new();
      width_reg  = CFG_W'(FW_RESET);
      height_reg = CFG_W'(FH_RESET);
      next_row   = 0;
      next_col   = 0;
      errors     = 0;
      checked    = 0;
      noted      = 0;
      foreach (two_up[i]) begin
        two_up[i] = '0;
        one_up[i] = '0;
      end
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    function void note_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                             logic fs);
      int           w;
      int           h;
      int           x;
      int           y;
      int           c;
      int           sum;
      px_t          cur;
      px_t          center;
      px_t          north;
      px_t          east;
      px_t          west;
      px_t          blurred;
      blur_result_t res;
      w = (width_reg < SIZE_MIN) ? SIZE_MIN : (width_reg > FRAME_MAX) ? FRAME_MAX : width_reg;
      h = (height_reg < SIZE_MIN) ? SIZE_MIN :
          (height_reg > FRAME_MAX) ? FRAME_MAX : height_reg;
      cur = {b, g, r};
      if (fs) begin
        next_row = 0;
        next_col = 0;
      end
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
      end
      if (next_row >= h) next_row = 0;
      x = next_col;
      y = next_row;
      center  = one_up[x];
      north   = two_up[x];
      blurred = center;
      if (y >= 2 && x != 0 && x != w - 1) begin
        east = one_up[x + 1];
        west = two_up[x - 1];
        for (c = 0; c < NUM_CH; c++) begin
          sum = 4 * center[c*CH_W +: CH_W] + north[c*CH_W +: CH_W] + cur[c*CH_W +: CH_W]
              + east[c*CH_W +: CH_W] + west[c*CH_W +: CH_W];
          blurred[c*CH_W +: CH_W] = CH_W'(sum >> 3);
        end
      end
      if (y >= 1) begin
        res.row      = POS_W'(y - 1);
        res.col      = POS_W'(x);
        res.red      = blurred[0 +: CH_W];
        res.green    = blurred[CH_W +: CH_W];
        res.blue     = blurred[2*CH_W +: CH_W];
        res.run_last = (y != h - 1);
        pending_pixels.push_back(res);
      end
      if (y == h - 1) begin
        res.row      = POS_W'(y);
        res.col      = POS_W'(x);
        res.red      = r;
        res.green    = g;
        res.blue     = b;
        res.run_last = 1'b1;
        pending_pixels.push_back(res);
      end
      two_up[x] = center;
      one_up[x] = cur;
      next_col = x + 1;
      if (next_col >= w) begin
        next_col = 0;
        next_row = y + 1;
        if (next_row >= h) next_row = 0;
      end
      noted++;
    endfunction

    function void compare(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                               logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
                               logic run_last);
      blur_result_t want;
      if (pending_pixels.size() == 0) begin
        $error("result with nothing pending: row %0d column %0d", row, col);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      compare("out_row", CH_W'(want.row), CH_W'(row));
      compare("out_column", CH_W'(want.col), CH_W'(col));
      compare("red_out", want.red, r);
      compare("green_out", want.green, g);
      compare("blue_out", want.blue, b);
      compare("run_last", CH_W'(want.run_last), CH_W'(run_last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  blur_checker sb;
  bit          sender_idle;
  bit          receiver_idle;
  int          ready_burst;
  int          random_items;
  int          settings;
  int          n;
  int          w;
  int          h;

  csb_pix_if pix_bus ();
  csb_res_if res_bus ();
  csb_cfg_if cfg_port ();

  cross_stencil_blur_stream #(
    .MAX_WIDTH  (FRAME_MAX),
    .MAX_HEIGHT (FRAME_MAX)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_bus),
    .out_res (res_bus),
    .cfg_bus (cfg_port)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      ready_burst   <= 0;
    end else if (ready_burst == 0) begin
      res_bus.ready <= !(receiver_idle && $urandom_range(0, 2) == 0);
      ready_burst   <= $urandom_range(1, 15);
    end else begin
      ready_burst <= ready_burst - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_bus.valid && pix_bus.ready)
        sb.note_pixel(pix_bus.red_in, pix_bus.green_in, pix_bus.blue_in,
                      pix_bus.frame_start);
      if (res_bus.valid && res_bus.ready)
        sb.check_result(res_bus.out_row, res_bus.out_column, res_bus.red_out,
                        res_bus.green_out, res_bus.blue_out, res_bus.run_last);
    end
  end

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return CH_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // drop valid, wait for every pending result, then give in-flight top-row pixels time
  task automatic settle();
    pix_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_frame_size(input int width_val, input int height_val);
    logic [CFG_IDX_W-1:0] idx [2];
    int                   value [2];
    int                   k;
    idx[0]   = REG_FRAME_WIDTH;
    idx[1]   = REG_FRAME_HEIGHT;
    value[0] = width_val;
    value[1] = height_val;
    for (k = 0; k < 2; k++) begin
      cfg_port.valid <= 1'b1;
      cfg_port.index <= idx[k];
      cfg_port.data  <= value[k][CFG_W-1:0];
      do @(posedge clk); while (!cfg_port.ready);
      sb.write_reg(idx[k], value[k][CFG_W-1:0]);
    end
    cfg_port.valid <= 1'b0;
    settings++;
  endtask

  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input logic fs, input bit hold);
    int gap;
    gap = (sender_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0 || hold) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold) begin
        do @(posedge clk); while (sb.outstanding() != 0);
      end
    end
    pix_bus.valid       <= 1'b1;
    pix_bus.red_in      <= r;
    pix_bus.green_in    <= g;
    pix_bus.blue_in     <= b;
    pix_bus.frame_start <= fs;
    do @(posedge clk); while (!pix_bus.ready);
  endtask

  task automatic stream_pixels(input int count, input bit first_start, input bit restarts,
                               input int hold_at);
    int  i;
    bit  fs;
    for (i = 0; i < count; i++) begin
      fs = (i == 0 && first_start) || (restarts && $urandom_range(0, 49) == 0);
      send_pixel(pick_channel(), pick_channel(), pick_channel(), fs, i == hold_at);
    end
  endtask

  initial begin
    #(LIMIT_CYCLES * 20);
    $display("cross_stencil_blur_stream: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    rst_n                <= 1'b0;
    pix_bus.valid        <= 1'b0;
    pix_bus.red_in       <= '0;
    pix_bus.green_in     <= '0;
    pix_bus.blue_in      <= '0;
    pix_bus.frame_start  <= 1'b0;
    cfg_port.valid       <= 1'b0;
    cfg_port.index       <= REG_FRAME_WIDTH;
    cfg_port.data        <= '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    settings      = 0;
    random_items  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full 4x3 frame, wrap into the next one, then restart mid-row
    set_frame_size(4, 3);
    for (int i = 0; i < 15; i++)
      send_pixel(STRIPES[i % 4], STRIPES[(i + 1) % 4], STRIPES[(i + 2) % 4],
                 i == 0 || i == 13, 1'b0);
    settle();
    // largest possible stencil sum
    set_frame_size(3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, i == 0, 1'b0);
    settle();

    // shrink width and height under the current position
    set_frame_size(10, 8);
    stream_pixels(47, 1'b1, 1'b0, -1);
    settle();
    set_frame_size(4, 5);
    stream_pixels(20, 1'b0, 1'b0, -1);
    settle();
    // shrink width only, hold the stream until drained once
    set_frame_size(10, 8);
    stream_pixels(47, 1'b1, 1'b0, -1);
    settle();
    set_frame_size(5, 8);
    stream_pixels(20, 1'b0, 1'b0, 10);
    settle();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= QUIET_ITEMS) begin
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
      end else begin
        sender_idle   = $urandom_range(0, 3) != 0;
        receiver_idle = $urandom_range(0, 3) != 0;
      end
      case ($urandom_range(0, 7))
        0: w = $urandom_range(0, 2);
        1: w = $urandom_range(FRAME_MAX + 1, CFG_MAX);
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 7))
        0: h = $urandom_range(0, 2);
        1: h = $urandom_range(FRAME_MAX + 1, CFG_MAX);
        default: h = $urandom_range(3, 8);
      endcase
      n = $urandom_range(10, 60);
      set_frame_size(w, h);
      stream_pixels(n, 1'b1, 1'b1,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1);
      random_items += n;
      settle();
    end

    repeat (20) @(posedge clk);
    $display("%0d pixels, %0d frame sizes: borders, wraps, restarts, shrinks, clamped sizes",
             sb.noted, settings);
    $display("stalls on both sides and one drained pause, %0d results checked", sb.checked);
    if (sb.errors == 0) begin
      $display("cross_stencil_blur_stream: match");
    end else begin
      $display("cross_stencil_blur_stream: mismatch");
    end
    $finish;
  end

endmodule
